[hw/rtl/las_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, codes, colors and the phase entry function of the LED
// animation sequencer.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int unsigned LED_COUNT = 4;

  // Operation codes of a command transaction
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_QUEUE   = 2'd1;
  localparam logic [1:0] OP_TRIGGER = 2'd2;

  // Animation codes
  localparam logic [2:0] ANIM_STOP      = 3'd0;
  localparam logic [2:0] ANIM_WAITING   = 3'd1;
  localparam logic [2:0] ANIM_ATTENTION = 3'd2;
  localparam logic [2:0] ANIM_EMERGENCY = 3'd3;
  localparam logic [2:0] ANIM_STANDBY   = 3'd4;
  localparam logic [2:0] ANIM_SPIN      = 3'd5;

  // Colors, red<<16 | green<<8 | blue
  localparam logic [7:0]  FULL      = 8'd255;
  localparam logic [7:0]  AMBER_GRN = 8'd38;
  localparam logic [23:0] COL_RED   = {FULL, 8'd0, 8'd0};
  localparam logic [23:0] COL_BLUE  = {8'd0, 8'd0, FULL};
  localparam logic [23:0] COL_AMBER = {FULL, AMBER_GRN, 8'd0};
  localparam logic [23:0] COL_OFF   = 24'd0;

  // Phase durations in milliseconds
  localparam logic [9:0] MS_BLINK_LONG  = 10'd1000;
  localparam logic [9:0] MS_BLINK_SHORT = 10'd100;
  localparam logic [9:0] MS_HALF        = 10'd400;
  localparam logic [9:0] MS_PAUSE       = 10'd500;
  localparam logic [9:0] MS_FOREVER     = 10'd0;

  // Attention: five on/off pairs, then one long dark phase
  localparam logic [4:0] ATT_PAUSE_PHASE = 5'd10;

  typedef struct packed {
    logic [LED_COUNT-1:0]       red;
    logic [LED_COUNT-1:0][23:0] rgb;
  } image_t;

  typedef struct packed {
    logic       ok;
    logic [9:0] ms;
    image_t     img;
  } phase_t;

  // Everything a result transaction shows
  typedef struct packed {
    image_t     img;
    logic [2:0] anim;
    logic       once;
  } view_t;

  localparam image_t IMG_DARK = '0;

  function automatic image_t all_red();
    image_t r;
    r.red = '1;
    for (int i = 0; i < LED_COUNT; i++) r.rgb[i] = COL_RED;
    return r;
  endfunction

  // Apply the entry actions of phase p and arm its wait; ok clear = play done
  function automatic phase_t enter_phase(input logic [2:0] anim,
                                         input logic [4:0] p,
                                         input image_t     img);
    phase_t     r;
    logic [1:0] prev;
    logic [1:0] cur;
    r.ok  = 1'b1;
    r.ms  = MS_FOREVER;
    r.img = img;
    prev  = p[2:1] - 2'd1;
    cur   = p[2:1];
    case (anim)
      ANIM_WAITING: begin
        if (p > 5'd1) begin
          r.ok = 1'b0;
        end else begin
          r.img = (p == 5'd0) ? all_red() : IMG_DARK;
          r.ms  = MS_BLINK_LONG;
        end
      end
      ANIM_ATTENTION: begin
        if (p < ATT_PAUSE_PHASE) begin
          r.img = p[0] ? IMG_DARK : all_red();
          r.ms  = MS_BLINK_SHORT;
        end else if (p == ATT_PAUSE_PHASE) begin
          r.ms = MS_PAUSE;
        end else begin
          r.ok = 1'b0;
        end
      end
      ANIM_EMERGENCY: begin
        if (p > 5'd1) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < LED_COUNT; i++) begin
            if (p == 5'd0) r.img.rgb[i] = (i >= 2) ? COL_RED : COL_OFF;
            else           r.img.rgb[i] = (i <= 1) ? COL_BLUE : COL_OFF;
          end
          r.ms = MS_HALF;
        end
      end
      ANIM_STANDBY: begin
        if (p != 5'd0) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < LED_COUNT; i++) r.img.rgb[i] = COL_AMBER;
        end
      end
      ANIM_SPIN: begin
        // Turn off the RGB LED lit by the previous step
        if (p >= 5'd2 && !p[0]) r.img.rgb[prev] = COL_OFF;
        if (p >= 5'(2 * LED_COUNT)) begin
          r.ok = 1'b0;
        end else begin
          if (!p[0]) begin
            r.img.red[cur] = 1'b1;
          end else begin
            r.img.red[cur] = 1'b0;
            r.img.rgb[cur] = COL_RED;
          end
          r.ms = MS_BLINK_SHORT;
        end
      end
      default: begin
        if (p != 5'd0) r.ok = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/las_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_cmd_if
// Command channel: tick, queue request or trigger with valid/ready.
// ----------------------------------------------------------------------------
interface las_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] animation;
  logic       repeat_mode;

  modport source (output valid, output op, output animation, output repeat_mode,
                  input ready);
  modport sink   (input valid, input op, input animation, input repeat_mode,
                  output ready);
endinterface

[hw/rtl/las_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_res_if
// Result channel: LED image and play status with valid/ready.
// ----------------------------------------------------------------------------
interface las_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  red_leds;
  logic [23:0] rgb_led0;
  logic [23:0] rgb_led1;
  logic [23:0] rgb_led2;
  logic [23:0] rgb_led3;
  logic [2:0]  active_animation;
  logic        playing_once;

  modport source (output valid, output red_leds, output rgb_led0, output rgb_led1,
                  output rgb_led2, output rgb_led3, output active_animation,
                  output playing_once, input ready);
  modport sink   (input valid, input red_leds, input rgb_led0, input rgb_led1,
                  input rgb_led2, input rgb_led3, input active_animation,
                  input playing_once, output ready);
endinterface

[hw/rtl/las_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_engine
// Sequencer state and its single-pass update for one command transaction.
// ----------------------------------------------------------------------------
module las_engine
  import las_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] op,
  input  logic [2:0] animation,
  input  logic       repeat_mode,
  output view_t      view_next
);

  logic [2:0] loop_choice, loop_choice_next;
  logic [2:0] once_choice, once_choice_next;
  logic       once_pending, once_pending_next;
  logic [2:0] cur_anim, cur_anim_next;
  logic [4:0] phase, phase_next;
  logic [9:0] ms_left, ms_left_next;
  image_t     img, img_next;
  logic       in_once, in_once_next;

  logic [2:0] req_anim;
  logic [9:0] ms_dec;
  logic [4:0] phase_inc;
  phase_t     adv;
  phase_t     restart;
  logic [2:0] start_anim;
  logic [2:0] store_loop;
  logic [2:0] store_once;
  logic       store_pend;

  // Map unknown animation codes to stop
  assign req_anim  = (animation > ANIM_SPIN) ? ANIM_STOP : animation;
  assign ms_dec    = ms_left - 10'd1;
  assign phase_inc = phase + 5'd1;
  assign adv       = enter_phase(cur_anim, phase_inc, img);

  // Request bookkeeping as a queue or trigger would leave it
  always_comb begin
    store_loop = loop_choice;
    store_once = once_choice;
    store_pend = once_pending;
    if (repeat_mode) begin
      store_loop = req_anim;
      store_pend = 1'b0;
    end else begin
      store_once = req_anim;
      store_pend = 1'b1;
    end
  end

  // Next state for one transaction
  always_comb begin
    loop_choice_next  = loop_choice;
    once_choice_next  = once_choice;
    once_pending_next = once_pending;
    cur_anim_next     = cur_anim;
    phase_next        = phase;
    ms_left_next      = ms_left;
    img_next          = img;
    in_once_next      = in_once;
    start_anim        = loop_choice;
    restart           = enter_phase(loop_choice, 5'd0, adv.img);
    case (op)
      OP_TICK: begin
        if (ms_left != 10'd0) begin
          if (ms_dec != 10'd0) begin
            ms_left_next = ms_dec;
          end else if (adv.ok) begin
            phase_next   = phase_inc;
            ms_left_next = adv.ms;
            img_next     = adv.img;
          end else begin
            if (in_once) begin
              // Once play finished: start a fresh play from dark
              start_anim = once_pending ? once_choice : loop_choice;
              restart    = enter_phase(start_anim, 5'd0, IMG_DARK);
              once_pending_next = 1'b0;
              in_once_next      = once_pending;
            end else begin
              // Loop wraps onto the current loop choice, image kept
              start_anim = loop_choice;
            end
            cur_anim_next = start_anim;
            phase_next    = 5'd0;
            ms_left_next  = restart.ms;
            img_next      = restart.img;
          end
        end
      end
      OP_QUEUE: begin
        loop_choice_next  = store_loop;
        once_choice_next  = store_once;
        once_pending_next = store_pend;
      end
      OP_TRIGGER: begin
        loop_choice_next  = store_loop;
        once_choice_next  = store_once;
        start_anim        = store_pend ? store_once : store_loop;
        restart           = enter_phase(start_anim, 5'd0, IMG_DARK);
        once_pending_next = 1'b0;
        in_once_next      = store_pend;
        cur_anim_next     = start_anim;
        phase_next        = 5'd0;
        ms_left_next      = restart.ms;
        img_next          = restart.img;
      end
      default: begin
      end
    endcase
  end

  // Commit on each accepted step
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_choice  <= ANIM_STOP;
      once_choice  <= ANIM_STOP;
      once_pending <= 1'b0;
      cur_anim     <= ANIM_STOP;
      phase        <= '0;
      ms_left      <= MS_FOREVER;
      img          <= IMG_DARK;
      in_once      <= 1'b0;
    end else if (step) begin
      loop_choice  <= loop_choice_next;
      once_choice  <= once_choice_next;
      once_pending <= once_pending_next;
      cur_anim     <= cur_anim_next;
      phase        <= phase_next;
      ms_left      <= ms_left_next;
      img          <= img_next;
      in_once      <= in_once_next;
    end
  end

  assign view_next.img  = img_next;
  assign view_next.anim = cur_anim_next;
  assign view_next.once = in_once_next;

endmodule

[hw/rtl/led_animation_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_animation_sequencer_top
// Input register, sequencer engine and result register for the LED
// animation sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  cmd     | in  | op, animation, repeat_mode
//  res     | out | red_leds, rgb_led0..3, active_animation, playing_once
//
//  One transaction per cycle sustained while results are taken; each command gives
//  one result, held first in the input register and then in the result register.
//  rst clears the sequencer state and both valid flags: stop animation in loop mode, LEDs dark.
//  A stalled result holds; the input register keeps taking commands while the
//  result register is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
module led_animation_sequencer_top
  import las_pkg::*;
(
  input logic      clk,
  input logic      rst,
  las_cmd_if.sink  cmd,
  las_res_if.source res
);

  logic       s1_valid;
  logic [1:0] s1_op;
  logic [2:0] s1_anim;
  logic       s1_mode;
  logic       s1_go;
  logic       out_valid;
  view_t      view_next;
  view_t      out_view;

  // Advance the held command when the result register can take it
  assign s1_go     = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op   <= cmd.op;
      s1_anim <= cmd.animation;
      s1_mode <= cmd.repeat_mode;
    end
  end

  las_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_go),
    .op          (s1_op),
    .animation   (s1_anim),
    .repeat_mode (s1_mode),
    .view_next   (view_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_view <= view_next;
    end
  end

  assign res.valid            = out_valid;
  assign res.red_leds         = out_view.img.red;
  assign res.rgb_led0         = out_view.img.rgb[0];
  assign res.rgb_led1         = out_view.img.rgb[1];
  assign res.rgb_led2         = out_view.img.rgb[2];
  assign res.rgb_led3         = out_view.img.rgb[3];
  assign res.active_animation = out_view.anim;
  assign res.playing_once     = out_view.once;

endmodule

[hw/rtl/las_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_chk
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
module las_chk
  import las_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [23:0] rgb0,
  input logic [23:0] rgb1,
  input logic [23:0] rgb2,
  input logic [23:0] rgb3,
  input logic [2:0]  anim
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Only legal animations are ever shown
  a_anim: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> anim <= ANIM_SPIN)
    else $error("illegal active animation");

  // Standby shows steady amber on all RGB LEDs
  a_standby: assert property (@(posedge clk) disable iff (rst)
    res_valid && anim == ANIM_STANDBY |->
      rgb0 == COL_AMBER && rgb1 == COL_AMBER && rgb2 == COL_AMBER && rgb3 == COL_AMBER)
    else $error("standby image wrong");

  // Emergency drives LED pairs together
  a_emerg: assert property (@(posedge clk) disable iff (rst)
    res_valid && anim == ANIM_EMERGENCY |-> rgb0 == rgb1 && rgb2 == rgb3)
    else $error("emergency pairs differ");

endmodule

bind led_animation_sequencer_top las_chk u_las_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .rgb0      (res.rgb_led0),
  .rgb1      (res.rgb_led1),
  .rgb2      (res.rgb_led2),
  .rgb3      (res.rgb_led3),
  .anim      (res.active_animation)
);
